// File: hdl/grc_pkg.sv
package grc_pkg;

    localparam int MAP_SIZE   = 32;
    localparam int MAP_AW     = $clog2(MAP_SIZE);
    localparam int MAP_DEPTH  = MAP_SIZE * MAP_SIZE;
    localparam int ADDR_W     = 2 * MAP_AW;
    localparam int SCREEN_W   = 800;
    localparam int SCREEN_H   = 800;
    localparam int FRAC_BITS  = 16;
    localparam int CELL_BITS  = 3;
    localparam int COL_W      = 10;
    localparam int POS_W      = 21;
    localparam int VEC_W      = 18;
    localparam int RAY_W      = 21;
    localparam int DIV_W      = 40;
    localparam int DIV_CW     = $clog2(DIV_W);
    localparam int DELTA_W    = 38;
    localparam int SD_W       = 46;
    localparam int MAPI_W     = 8;
    localparam int NUM_W      = 26;
    localparam int WALK_MAX   = 2 * MAP_SIZE;
    localparam int WALK_CW    = $clog2(WALK_MAX + 1);
    localparam int LINE_W     = 11;
    localparam int LINE_MAX   = 2 * SCREEN_H;

    localparam logic [2:0] REG_CAM_X   = 3'd0;
    localparam logic [2:0] REG_CAM_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;

    typedef enum logic {
        OP_WRITE,
        OP_CAST
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [MAP_AW-1:0]     row;
        logic [MAP_AW-1:0]     col;
        logic [CELL_BITS-1:0]  value;
        logic [COL_W-1:0]      column;
    } q_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [VEC_W-1:0]  dir_x;
        logic [VEC_W-1:0]  dir_y;
        logic [VEC_W-1:0]  plane_x;
        logic [VEC_W-1:0]  plane_y;
    } cfg_t;

    typedef struct packed {
        logic hold;
    } back_status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM_GO,
        ST_RAY_MUL,
        ST_RAY_SUM,
        ST_DLX_GO,
        ST_DLX_WAIT,
        ST_DLY_GO,
        ST_DLY_WAIT,
        ST_SIDE_MUL,
        ST_WALK_INIT,
        ST_WALK_STEP,
        ST_WALK_CHECK,
        ST_PERP_GO,
        ST_PERP_WAIT,
        ST_LINE_GO,
        ST_LINE_WAIT,
        ST_SPAN,
        ST_DONE
    } state_t;

endpackage

// File: hdl/grc_ram.sv
module grc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/grc_div.sv
module grc_div
    import grc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W+1:0]  diff;
    logic              ge;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        rem_sh    = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, den_reg};
        ge        = !diff[DIV_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W:0] : rem_sh;
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/grc_front.sv
module grc_front
    import grc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 action,
    input  logic [MAP_AW-1:0]    cell_row,
    input  logic [MAP_AW-1:0]    cell_col,
    input  logic [CELL_BITS-1:0] cell_value,
    input  logic [COL_W-1:0]     column,
    input  back_status_t         status,
    output logic                 q_valid,
    output q_item_t              q_item,
    input  logic                 q_pop
);

    q_item_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    q_item_t     item;

    always_comb
    begin
        item.op     = action ? OP_CAST : OP_WRITE;
        item.row    = cell_row;
        item.col    = cell_col;
        item.value  = cell_value;
        item.column = column;
    end

    assign item_ready = (count_reg != 2'd2) && !status.hold;
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// File: hdl/grc_back.sv
module grc_back
    import grc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  q_item_t              q_item,
    output logic                 q_pop,
    output back_status_t         status,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [COL_W-1:0]     column_out,
    output logic [COL_W-1:0]     draw_start,
    output logic [COL_W-1:0]     draw_end,
    output logic [CELL_BITS-1:0] wall_kind,
    output logic                 hit_side,
    output logic                 hit_found
);

    localparam logic [DIV_W-1:0] DELTA_SAT  = DIV_W'((64'd1 << DELTA_W) - 64'd1);
    localparam logic [DIV_W-1:0] RECIP_NUM  = DIV_W'(64'd1 << (2 * FRAC_BITS));
    localparam logic [DIV_W-1:0] LINE_NUM   = DIV_W'(64'(SCREEN_H) << FRAC_BITS);
    localparam logic [DIV_W-1:0] LINE_LIM   = DIV_W'(LINE_MAX);
    localparam logic [VEC_W-1:0] ONE_V      = VEC_W'(1 << FRAC_BITS);
    localparam logic [FRAC_BITS:0] ONE_F    = (FRAC_BITS+1)'(1 << FRAC_BITS);
    localparam logic [LINE_W-1:0] HALF_H    = LINE_W'(SCREEN_H / 2);
    localparam logic [LINE_W-1:0] LAST_ROW  = LINE_W'(SCREEN_H - 1);
    localparam logic [LINE_W:0] SCREEN_HL   = (LINE_W+1)'(SCREEN_H);
    localparam logic signed [MAPI_W-1:0] STEP_ONE = MAPI_W'(1);
    // 2^32 / SCREEN_W rounded up; column * 2^17 / SCREEN_W is then
    // (column * CAM_RECIP) >> 15, exact for every 10-bit column.
    localparam logic [23:0] CAM_RECIP =
        24'(((64'd1 << 32) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));
    localparam int CAM_SH = 32 - FRAC_BITS - 1;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [WALK_CW-1:0]         walk_cnt_reg, walk_cnt_next;
    logic                       res_valid_reg, res_valid_next;

    logic [COL_W-1:0]           col_reg, col_next;
    logic signed [VEC_W-1:0]    cam_reg, cam_next;
    logic signed [2*VEC_W-1:0]  ray_px_reg, ray_px_next;
    logic signed [2*VEC_W-1:0]  ray_py_reg, ray_py_next;
    logic signed [RAY_W-1:0]    rdx_reg, rdx_next;
    logic signed [RAY_W-1:0]    rdy_reg, rdy_next;
    logic [DELTA_W-1:0]         dlx_reg, dlx_next;
    logic [DELTA_W-1:0]         dly_reg, dly_next;
    logic [FRAC_BITS+DELTA_W:0] side_px_reg, side_px_next;
    logic [FRAC_BITS+DELTA_W:0] side_py_reg, side_py_next;
    logic [SD_W-1:0]            sdx_reg, sdx_next;
    logic [SD_W-1:0]            sdy_reg, sdy_next;
    logic signed [MAPI_W-1:0]   mx_reg, mx_next;
    logic signed [MAPI_W-1:0]   my_reg, my_next;
    logic                       side_reg, side_next;
    logic                       inmap_reg, inmap_next;
    logic                       hit_reg, hit_next;
    logic [CELL_BITS-1:0]       kind_reg, kind_next;
    logic                       perp_bad_reg, perp_bad_next;
    logic [DIV_W-1:0]           perp_reg, perp_next;
    logic [LINE_W-1:0]          line_reg, line_next;
    logic [COL_W-1:0]           ds_reg, ds_next;
    logic [COL_W-1:0]           de_reg, de_next;

    logic [COL_W-1:0]           res_col_reg, res_col_next;
    logic [COL_W-1:0]           res_ds_reg, res_ds_next;
    logic [COL_W-1:0]           res_de_reg, res_de_next;
    logic [CELL_BITS-1:0]       res_kind_reg, res_kind_next;
    logic                       res_side_reg, res_side_next;
    logic                       res_hit_reg, res_hit_next;

    logic                       div_start;
    logic [DIV_W-1:0]           div_num;
    logic [DIV_W-1:0]           div_den;
    logic                       div_busy;
    logic                       div_done;
    logic [DIV_W-1:0]           div_q;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [CELL_BITS-1:0]       ram_wdata;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [CELL_BITS-1:0]       ram_rdata;

    logic [COL_W+23:0]          cam_prod;
    logic [RAY_W-1:0]           abs_rdx;
    logic [RAY_W-1:0]           abs_rdy;
    logic [FRAC_BITS:0]         frac_x;
    logic [FRAC_BITS:0]         frac_y;
    logic signed [MAPI_W-1:0]   mx_step;
    logic signed [MAPI_W-1:0]   my_step;
    logic [CELL_BITS-1:0]       cell_seen;
    logic signed [NUM_W-1:0]    num;
    logic signed [RAY_W-1:0]    rd_sel;
    logic [NUM_W-1:0]           abs_num;
    logic [RAY_W-1:0]           abs_rd;
    logic [LINE_W-1:0]          half_line;
    logic [LINE_W:0]            de_sum;

    grc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    grc_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared datapath terms.
    always_comb
    begin
        cam_prod  = (COL_W+24)'(col_reg) * (COL_W+24)'(CAM_RECIP);
        abs_rdx   = rdx_reg[RAY_W-1] ? RAY_W'(-rdx_reg) : RAY_W'(rdx_reg);
        abs_rdy   = rdy_reg[RAY_W-1] ? RAY_W'(-rdy_reg) : RAY_W'(rdy_reg);
        frac_x    = rdx_reg[RAY_W-1] ? {1'b0, cfg.pos_x[FRAC_BITS-1:0]}
                                     : ONE_F - {1'b0, cfg.pos_x[FRAC_BITS-1:0]};
        frac_y    = rdy_reg[RAY_W-1] ? {1'b0, cfg.pos_y[FRAC_BITS-1:0]}
                                     : ONE_F - {1'b0, cfg.pos_y[FRAC_BITS-1:0]};
        mx_step   = rdx_reg[RAY_W-1] ? mx_reg - STEP_ONE : mx_reg + STEP_ONE;
        my_step   = rdy_reg[RAY_W-1] ? my_reg - STEP_ONE : my_reg + STEP_ONE;
        cell_seen = inmap_reg ? ram_rdata : '0;
        // Distance from the camera to the crossed grid line on the hit axis.
        if (!side_reg)
        begin
            num = ($signed(NUM_W'(mx_reg)) <<< FRAC_BITS)
                - $signed(NUM_W'(cfg.pos_x))
                + (rdx_reg[RAY_W-1] ? $signed(NUM_W'(ONE_F)) : '0);
            rd_sel = rdx_reg;
        end
        else
        begin
            num = ($signed(NUM_W'(my_reg)) <<< FRAC_BITS)
                - $signed(NUM_W'(cfg.pos_y))
                + (rdy_reg[RAY_W-1] ? $signed(NUM_W'(ONE_F)) : '0);
            rd_sel = rdy_reg;
        end
        abs_num   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        abs_rd    = rd_sel[RAY_W-1] ? RAY_W'(-rd_sel) : RAY_W'(rd_sel);
        half_line = line_reg >> 1;
        de_sum    = {1'b0, half_line} + {1'b0, HALF_H};
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        walk_cnt_next  = walk_cnt_reg;
        res_valid_next = res_valid_reg;
        col_next       = col_reg;
        cam_next       = cam_reg;
        ray_px_next    = ray_px_reg;
        ray_py_next    = ray_py_reg;
        rdx_next       = rdx_reg;
        rdy_next       = rdy_reg;
        dlx_next       = dlx_reg;
        dly_next       = dly_reg;
        side_px_next   = side_px_reg;
        side_py_next   = side_py_reg;
        sdx_next       = sdx_reg;
        sdy_next       = sdy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        side_next      = side_reg;
        inmap_next     = inmap_reg;
        hit_next       = hit_reg;
        kind_next      = kind_reg;
        perp_bad_next  = perp_bad_reg;
        perp_next      = perp_reg;
        line_next      = line_reg;
        ds_next        = ds_reg;
        de_next        = de_reg;
        res_col_next   = res_col_reg;
        res_ds_next    = res_ds_reg;
        res_de_next    = res_de_reg;
        res_kind_next  = res_kind_reg;
        res_side_next  = res_side_reg;
        res_hit_next   = res_hit_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        ram_we         = 1'b0;
        ram_waddr      = {q_item.row, q_item.col};
        ram_wdata      = q_item.value;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        col_next   = q_item.column;
                        state_next = ST_CAM_GO;
                    end
                end
            end
            ST_CAM_GO:
            begin
                cam_next   = $signed(VEC_W'(cam_prod >> CAM_SH) - ONE_V);
                state_next = ST_RAY_MUL;
            end
            ST_RAY_MUL:
            begin
                ray_px_next = $signed(cfg.plane_x) * cam_reg;
                ray_py_next = $signed(cfg.plane_y) * cam_reg;
                state_next  = ST_RAY_SUM;
            end
            ST_RAY_SUM:
            begin
                // The arithmetic shift floors negative products as well.
                rdx_next = $signed(RAY_W'($signed(cfg.dir_x)))
                         + $signed(RAY_W'(ray_px_reg >>> FRAC_BITS));
                rdy_next = $signed(RAY_W'($signed(cfg.dir_y)))
                         + $signed(RAY_W'(ray_py_reg >>> FRAC_BITS));
                mx_next  = $signed(MAPI_W'(cfg.pos_x[POS_W-1:FRAC_BITS]));
                my_next  = $signed(MAPI_W'(cfg.pos_y[POS_W-1:FRAC_BITS]));
                state_next = ST_DLX_GO;
            end
            ST_DLX_GO:
            begin
                div_start  = 1'b1;
                div_num    = RECIP_NUM;
                div_den    = DIV_W'(abs_rdx);
                state_next = ST_DLX_WAIT;
            end
            ST_DLX_WAIT:
            begin
                if (div_done)
                begin
                    if (rdx_reg == '0 || div_q > DELTA_SAT)
                    begin
                        dlx_next = DELTA_SAT[DELTA_W-1:0];
                    end
                    else
                    begin
                        dlx_next = div_q[DELTA_W-1:0];
                    end
                    state_next = ST_DLY_GO;
                end
            end
            ST_DLY_GO:
            begin
                div_start  = 1'b1;
                div_num    = RECIP_NUM;
                div_den    = DIV_W'(abs_rdy);
                state_next = ST_DLY_WAIT;
            end
            ST_DLY_WAIT:
            begin
                if (div_done)
                begin
                    if (rdy_reg == '0 || div_q > DELTA_SAT)
                    begin
                        dly_next = DELTA_SAT[DELTA_W-1:0];
                    end
                    else
                    begin
                        dly_next = div_q[DELTA_W-1:0];
                    end
                    state_next = ST_SIDE_MUL;
                end
            end
            ST_SIDE_MUL:
            begin
                side_px_next = frac_x * dlx_reg;
                side_py_next = frac_y * dly_reg;
                state_next   = ST_WALK_INIT;
            end
            ST_WALK_INIT:
            begin
                sdx_next      = SD_W'(side_px_reg >> FRAC_BITS);
                sdy_next      = SD_W'(side_py_reg >> FRAC_BITS);
                walk_cnt_next = '0;
                state_next    = ST_WALK_STEP;
            end
            ST_WALK_STEP:
            begin
                if (sdx_reg < sdy_reg)
                begin
                    sdx_next  = sdx_reg + SD_W'(dlx_reg);
                    mx_next   = mx_step;
                    side_next = 1'b0;
                end
                else
                begin
                    sdy_next  = sdy_reg + SD_W'(dly_reg);
                    my_next   = my_step;
                    side_next = 1'b1;
                end
                // Look up the cell just entered; off-map cells count as empty.
                ram_re        = 1'b1;
                ram_raddr     = {mx_next[MAP_AW-1:0], my_next[MAP_AW-1:0]};
                inmap_next    = (mx_next[MAPI_W-1:MAP_AW] == '0)
                             && (my_next[MAPI_W-1:MAP_AW] == '0);
                walk_cnt_next = walk_cnt_reg + 1'b1;
                state_next    = ST_WALK_CHECK;
            end
            ST_WALK_CHECK:
            begin
                if (cell_seen != '0)
                begin
                    hit_next   = 1'b1;
                    kind_next  = cell_seen;
                    state_next = ST_PERP_GO;
                end
                else if (walk_cnt_reg == WALK_CW'(WALK_MAX))
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK_STEP;
                end
            end
            ST_PERP_GO:
            begin
                // A distance that is zero or behind the camera gives the full line.
                perp_bad_next = (rd_sel == '0) || (num == '0)
                             || (num[NUM_W-1] != rd_sel[RAY_W-1]);
                div_start  = 1'b1;
                div_num    = DIV_W'({abs_num, {FRAC_BITS{1'b0}}});
                div_den    = DIV_W'(abs_rd);
                state_next = ST_PERP_WAIT;
            end
            ST_PERP_WAIT:
            begin
                if (div_done)
                begin
                    perp_next = div_q;
                    if (perp_bad_reg || div_q == '0)
                    begin
                        line_next  = LINE_W'(LINE_MAX);
                        state_next = ST_SPAN;
                    end
                    else
                    begin
                        state_next = ST_LINE_GO;
                    end
                end
            end
            ST_LINE_GO:
            begin
                div_start  = 1'b1;
                div_num    = LINE_NUM;
                div_den    = perp_reg;
                state_next = ST_LINE_WAIT;
            end
            ST_LINE_WAIT:
            begin
                if (div_done)
                begin
                    line_next  = (div_q > LINE_LIM) ? LINE_W'(LINE_MAX)
                                                    : div_q[LINE_W-1:0];
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                ds_next    = (half_line >= HALF_H) ? '0
                                                   : COL_W'(HALF_H - half_line);
                de_next    = (de_sum >= SCREEN_HL) ? COL_W'(LAST_ROW)
                                                   : COL_W'(de_sum);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next = 1'b1;
                    res_col_next   = col_reg;
                    res_ds_next    = hit_reg ? ds_reg : '0;
                    res_de_next    = hit_reg ? de_reg : '0;
                    res_kind_next  = hit_reg ? kind_reg : '0;
                    res_side_next  = hit_reg ? side_reg : 1'b0;
                    res_hit_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            walk_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            walk_cnt_reg  <= walk_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        cam_reg      <= cam_next;
        ray_px_reg   <= ray_px_next;
        ray_py_reg   <= ray_py_next;
        rdx_reg      <= rdx_next;
        rdy_reg      <= rdy_next;
        dlx_reg      <= dlx_next;
        dly_reg      <= dly_next;
        side_px_reg  <= side_px_next;
        side_py_reg  <= side_py_next;
        sdx_reg      <= sdx_next;
        sdy_reg      <= sdy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        side_reg     <= side_next;
        inmap_reg    <= inmap_next;
        hit_reg      <= hit_next;
        kind_reg     <= kind_next;
        perp_bad_reg <= perp_bad_next;
        perp_reg     <= perp_next;
        line_reg     <= line_next;
        ds_reg       <= ds_next;
        de_reg       <= de_next;
        res_col_reg  <= res_col_next;
        res_ds_reg   <= res_ds_next;
        res_de_reg   <= res_de_next;
        res_kind_reg <= res_kind_next;
        res_side_reg <= res_side_next;
        res_hit_reg  <= res_hit_next;
    end

    assign status.hold  = (state_reg == ST_CLEAR);
    assign result_valid = res_valid_reg;
    assign column_out   = res_col_reg;
    assign draw_start   = res_ds_reg;
    assign draw_end     = res_de_reg;
    assign wall_kind    = res_kind_reg;
    assign hit_side     = res_side_reg;
    assign hit_found    = res_hit_reg;

`ifndef SYNTHESIS
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !res_valid_reg)
        else $error("result presented during map clear");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !(walk_cnt_reg > WALK_CW'(WALK_MAX)))
        else $error("grid walk ran past its step limit");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

// File: hdl/grid_ray_caster_core.sv
// Map write transfer: written into the map when the back end pops it from the queue; one per cycle
// sustained while no cast is in work. Cast transfer: the result time is set by the grid walk (at most
// 64 steps) and up to four passes of the shared serial divider; a miss skips the distance work
// and two of those passes.
// One cast is in work at a time; a two-entry queue and the result register decouple it.
// After rst_n is released all 1024 tile map cells are cleared with item_ready low;
// configuration registers reset to their defaults at once.
module grid_ray_caster_core
    import grc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 action,
    input  logic [MAP_AW-1:0]    cell_row,
    input  logic [MAP_AW-1:0]    cell_col,
    input  logic [CELL_BITS-1:0] cell_value,
    input  logic [COL_W-1:0]     column,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [COL_W-1:0]     column_out,
    output logic [COL_W-1:0]     draw_start,
    output logic [COL_W-1:0]     draw_end,
    output logic [CELL_BITS-1:0] wall_kind,
    output logic                 hit_side,
    output logic                 hit_found
);

    cfg_t         cfg_reg, cfg_next;
    logic         wr_en;
    logic [2:0]   reg_idx;
    q_item_t      q_item;
    logic         q_valid;
    logic         q_pop;
    back_status_t status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_CAM_X:   cfg_next.pos_x   = pwdata[POS_W-1:0];
                REG_CAM_Y:   cfg_next.pos_y   = pwdata[POS_W-1:0];
                REG_DIR_X:   cfg_next.dir_x   = pwdata[VEC_W-1:0];
                REG_DIR_Y:   cfg_next.dir_y   = pwdata[VEC_W-1:0];
                REG_PLANE_X: cfg_next.plane_x = pwdata[VEC_W-1:0];
                REG_PLANE_Y: cfg_next.plane_y = pwdata[VEC_W-1:0];
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAM_X:   prdata = 32'(cfg_reg.pos_x);
            REG_CAM_Y:   prdata = 32'(cfg_reg.pos_y);
            REG_DIR_X:   prdata = 32'(cfg_reg.dir_x);
            REG_DIR_Y:   prdata = 32'(cfg_reg.dir_y);
            REG_PLANE_X: prdata = 32'(cfg_reg.plane_x);
            REG_PLANE_Y: prdata = 32'(cfg_reg.plane_y);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x   <= POS_W'(22 << FRAC_BITS);
            cfg_reg.pos_y   <= POS_W'(12 << FRAC_BITS);
            cfg_reg.dir_x   <= VEC_W'(-(1 << FRAC_BITS));
            cfg_reg.dir_y   <= '0;
            cfg_reg.plane_x <= '0;
            cfg_reg.plane_y <= VEC_W'(43254);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    grc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .action     (action),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cell_value (cell_value),
        .column     (column),
        .status     (status),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    grc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .column_out   (column_out),
        .draw_start   (draw_start),
        .draw_end     (draw_end),
        .wall_kind    (wall_kind),
        .hit_side     (hit_side),
        .hit_found    (hit_found)
    );

endmodule

// File: sim/grc_checker.sv
`timescale 1ns / 1ps

module grc_checker
    import grc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  logic                 action,
    input  logic [MAP_AW-1:0]    cell_row,
    input  logic [MAP_AW-1:0]    cell_col,
    input  logic [CELL_BITS-1:0] cell_value,
    input  logic [COL_W-1:0]     column,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  logic [COL_W-1:0]     column_out,
    input  logic [COL_W-1:0]     draw_start,
    input  logic [COL_W-1:0]     draw_end,
    input  logic [CELL_BITS-1:0] wall_kind,
    input  logic                 hit_side,
    input  logic                 hit_found,
    output int                   errors,
    output int                   pending,
    output int                   casts_done,
    output int                   walls_hit,
    output int                   cells_written
);

    typedef struct packed {
        logic [COL_W-1:0]     column;
        logic [COL_W-1:0]     start;
        logic [COL_W-1:0]     stop;
        logic [CELL_BITS-1:0] kind;
        logic                 side;
        logic                 found;
    } stripe_t;

    localparam longint ONE       = 64'sd1 << FRAC_BITS;
    localparam longint DELTA_SAT = (64'sd1 << DELTA_W) - 1;

    logic [CELL_BITS-1:0] tiles [MAP_DEPTH];
    cfg_t                 cam_cfg;
    stripe_t              stripes_due [$];

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function automatic longint unsigned inv_step(input longint r);
        longint unsigned mag;
        longint unsigned q;
        if (r == 0)
            return DELTA_SAT;
        mag = (r < 0) ? -r : r;
        q = (64'd1 << (2 * FRAC_BITS)) / mag;
        return (q > DELTA_SAT) ? DELTA_SAT : q;
    endfunction

    function automatic logic [CELL_BITS-1:0] cell_at(input longint r, input longint c);
        if (r < 0 || c < 0 || r >= MAP_SIZE || c >= MAP_SIZE)
            return '0;
        return tiles[r * MAP_SIZE + c];
    endfunction

    function automatic stripe_t trace_column(input logic [COL_W-1:0] col);
        stripe_t res;
        longint px, py, cam, rdx, rdy, mx, my, stx, sty, num, rd, perp, line, ds, de;
        longint dir_x, dir_y, pl_x, pl_y;
        longint unsigned dlx, dly, sdx, sdy, fr;
        logic [CELL_BITS-1:0] kind;
        logic side;
        logic hit;
        px = longint'(cam_cfg.pos_x);
        py = longint'(cam_cfg.pos_y);
        dir_x = longint'($signed(cam_cfg.dir_x));
        dir_y = longint'($signed(cam_cfg.dir_y));
        pl_x = longint'($signed(cam_cfg.plane_x));
        pl_y = longint'($signed(cam_cfg.plane_y));
        cam = longint'(((64'(col) * 2) << FRAC_BITS) / SCREEN_W) - ONE;
        rdx = dir_x + ((pl_x * cam) >>> FRAC_BITS);
        rdy = dir_y + ((pl_y * cam) >>> FRAC_BITS);
        mx = px >>> FRAC_BITS;
        my = py >>> FRAC_BITS;
        dlx = inv_step(rdx);
        dly = inv_step(rdy);
        if (rdx < 0) begin stx = -1; fr = px - mx * ONE; end
        else begin stx = 1; fr = (mx + 1) * ONE - px; end
        sdx = (fr * dlx) >> FRAC_BITS;
        if (rdy < 0) begin sty = -1; fr = py - my * ONE; end
        else begin sty = 1; fr = (my + 1) * ONE - py; end
        sdy = (fr * dly) >> FRAC_BITS;
        side = 1'b0;
        hit = 1'b0;
        kind = '0;
        for (int n = 0; n < WALK_MAX && !hit; n++)
        begin
            if (sdx < sdy)
            begin
                sdx += dlx; mx += stx; side = 1'b0;
            end
            else
            begin
                sdy += dly; my += sty; side = 1'b1;
            end
            kind = cell_at(mx, my);
            hit = (kind != 0);
        end
        res = '0;
        res.column = col;
        if (!hit)
            return res;
        if (side == 1'b0)
        begin
            num = mx * ONE - px + ((stx < 0) ? ONE : 0);
            rd = rdx;
        end
        else
        begin
            num = my * ONE - py + ((sty < 0) ? ONE : 0);
            rd = rdy;
        end
        perp = (rd == 0) ? 0 : (num * ONE) / rd;
        if (perp <= 0)
            line = LINE_MAX;
        else
        begin
            line = (longint'(SCREEN_H) * ONE) / perp;
            if (line > LINE_MAX)
                line = LINE_MAX;
        end
        ds = SCREEN_H / 2 - line / 2;
        if (ds < 0)
            ds = 0;
        de = line / 2 + SCREEN_H / 2;
        if (de >= SCREEN_H)
            de = SCREEN_H - 1;
        res.start = ds[COL_W-1:0];
        res.stop = de[COL_W-1:0];
        res.kind = kind;
        res.side = side;
        res.found = 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (tiles[i])
                tiles[i] = '0;
            cam_cfg.pos_x = 21'd1441792;
            cam_cfg.pos_y = 21'd786432;
            cam_cfg.dir_x = -18'sd65536;
            cam_cfg.dir_y = '0;
            cam_cfg.plane_x = '0;
            cam_cfg.plane_y = 18'd43254;
            stripes_due.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CAM_X:   cam_cfg.pos_x = pwdata[POS_W-1:0];
                    REG_CAM_Y:   cam_cfg.pos_y = pwdata[POS_W-1:0];
                    REG_DIR_X:   cam_cfg.dir_x = pwdata[VEC_W-1:0];
                    REG_DIR_Y:   cam_cfg.dir_y = pwdata[VEC_W-1:0];
                    REG_PLANE_X: cam_cfg.plane_x = pwdata[VEC_W-1:0];
                    REG_PLANE_Y: cam_cfg.plane_y = pwdata[VEC_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                if (op_t'(action) == OP_WRITE)
                begin
                    tiles[{cell_row, cell_col}] = cell_value;
                    cells_written++;
                end
                else
                    stripes_due.push_back(trace_column(column));
            end
            if (result_valid && result_ready)
            begin
                stripe_t want;
                if (stripes_due.size() == 0)
                    report($sformatf("result for column %0d with none expected", column_out));
                else
                begin
                    want = stripes_due.pop_front();
                    casts_done++;
                    if (want.found)
                        walls_hit++;
                    if (column_out !== want.column)
                        report($sformatf("column_out %0d, want %0d", column_out, want.column));
                    if (draw_start !== want.start)
                        report($sformatf("col %0d draw_start %0d, want %0d",
                                         want.column, draw_start, want.start));
                    if (draw_end !== want.stop)
                        report($sformatf("col %0d draw_end %0d, want %0d",
                                         want.column, draw_end, want.stop));
                    if (wall_kind !== want.kind)
                        report($sformatf("col %0d wall_kind %0d, want %0d",
                                         want.column, wall_kind, want.kind));
                    if (hit_side !== want.side)
                        report($sformatf("col %0d hit_side %0d, want %0d",
                                         want.column, hit_side, want.side));
                    if (hit_found !== want.found)
                        report($sformatf("col %0d hit_found %0d, want %0d",
                                         want.column, hit_found, want.found));
                end
            end
            pending = stripes_due.size();
        end
    end

endmodule

// File: sim/tb_grid_ray_caster_core.sv
`timescale 1ns / 1ps

module tb_grid_ray_caster_core;
    import grc_pkg::*;

    localparam int STALL_LIMIT = 40000;
    // Register indexes past the end of the list; writes there are ignored.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_ready;
    logic action = 1'b0;
    logic [MAP_AW-1:0] cell_row = '0;
    logic [MAP_AW-1:0] cell_col = '0;
    logic [CELL_BITS-1:0] cell_value = '0;
    logic [COL_W-1:0] column = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [COL_W-1:0] column_out;
    logic [COL_W-1:0] draw_start;
    logic [COL_W-1:0] draw_end;
    logic [CELL_BITS-1:0] wall_kind;
    logic hit_side;
    logic hit_found;

    int errors, pending, casts_done, walls_hit, cells_written;
    int quiet_cycles;
    int items_sent;
    logic calm = 1'b0;

    always #5 clk = ~clk;

    grid_ray_caster_core u_dut (.*);

    grc_checker u_check (.*);

    // Result back-pressure is random, but in the long calm stretch neither side idles.
    always @(posedge clk)
        result_ready <= calm || ($urandom_range(99) >= 18);

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(input op_t op, input logic [MAP_AW-1:0] r, input logic [MAP_AW-1:0] c,
                        input logic [CELL_BITS-1:0] v, input logic [COL_W-1:0] col);
        if (!calm && $urandom_range(99) < 18)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= op;
        cell_row <= r;
        cell_col <= c;
        cell_value <= v;
        column <= col;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        calm <= (items_sent >= 500 && items_sent < 750);
    endtask

    task automatic put_cell(input int r, input int c, input int v);
        send(OP_WRITE, r[MAP_AW-1:0], c[MAP_AW-1:0], v[CELL_BITS-1:0],
             COL_W'($urandom_range(1023)));
    endtask

    task automatic cast(input int col);
        send(OP_CAST, MAP_AW'($urandom), MAP_AW'($urandom), CELL_BITS'($urandom),
             col[COL_W-1:0]);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // Map writes give no result and may still be in flight.
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_camera(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [VEC_W-1:0] dx, input logic [VEC_W-1:0] dy,
                              input logic [VEC_W-1:0] plx, input logic [VEC_W-1:0] ply);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(REG_CAM_X, {junk[31:POS_W], px});
        reg_write(REG_CAM_Y, {junk[31:POS_W], py});
        reg_write(REG_DIR_X, {junk[31:VEC_W], dx});
        reg_write(REG_DIR_Y, {junk[31:VEC_W], dy});
        reg_write(REG_PLANE_X, {junk[31:VEC_W], plx});
        reg_write(REG_PLANE_Y, {junk[31:VEC_W], ply});
    endtask

    task automatic random_phase(input int count, input bit pause_midway);
        int pick;
        if ($urandom_range(99) < 60)
            for (int i = 0; i < MAP_SIZE; i++)
            begin
                put_cell(0, i, $urandom_range(7, 1));
                put_cell(MAP_SIZE - 1, i, $urandom_range(7, 1));
                put_cell(i, 0, $urandom_range(7, 1));
                put_cell(i, MAP_SIZE - 1, $urandom_range(7, 1));
            end
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                drain();
            pick = $urandom_range(99);
            if (pick < 25)
                put_cell($urandom_range(31), $urandom_range(31),
                         ($urandom_range(3) == 0) ? 0 : $urandom_range(7));
            else if (pick < 30)
                cast($urandom_range(1023));
            else
                cast($urandom_range(SCREEN_W - 1));
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty map: every ray runs out of steps.
        cast(0);
        cast(SCREEN_W - 1);
        // Walls in front of the default camera, including the adjacent cell.
        put_cell(10, 12, 5);
        put_cell(21, 12, 3);
        cast(400);
        put_cell(21, 12, 0);
        cast(400);
        cast(399);
        cast(0);
        cast(1023);
        put_cell(0, 0, 7);
        put_cell(31, 31, 1);
        put_cell(31, 0, 2);
        put_cell(0, 31, 6);
        put_cell(5, 17, 0);
        put_cell(10, 12, 0);
        cast(200);
        cast(600);
        drain();
        reg_write(REG_SPARE_A, $urandom);
        reg_write(REG_SPARE_B, $urandom);

        random_phase(200, 1'b0);
        set_camera(21'(5 << 16) + 21'h8000, 21'(27 << 16) + 21'h4000,
                   18'd0, 18'd65536, 18'd43254, 18'd0);
        random_phase(200, 1'b1);
        set_camera(21'h1FFFFF, 21'h1FFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        random_phase(120, 1'b0);
        set_camera('0, '0, 18'h20000, 18'h20000, 18'h20000, 18'h20000);
        random_phase(120, 1'b0);
        for (int p = 0; p < 3; p++)
        begin
            set_camera(POS_W'($urandom_range(31 << 16, 1 << 16)),
                       POS_W'($urandom_range(31 << 16, 1 << 16)),
                       VEC_W'($urandom), VEC_W'($urandom), VEC_W'($urandom), VEC_W'($urandom));
            random_phase(180, 1'b0);
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d items: %0d map writes, %0d casts (%0d hit a wall).",
                 items_sent, cells_written, casts_done, walls_hit);
        $display("Camera settings: reset, mid-map, all-max, all-min and random.");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hdl/grc_pkg.sv
hdl/grc_ram.sv
hdl/grc_div.sv
hdl/grc_front.sv
hdl/grc_back.sv
hdl/grid_ray_caster_core.sv
sim/grc_checker.sv
sim/tb_grid_ray_caster_core.sv
